// ----- hw/rtl/vrte_pkg.sv -----
// ----------------------------------------------------------------------------
// vrte_pkg: shared types, widths and constants of the voltage ramp time encoder
// Field widths, register indexes, prescaler codes and the divide-by-1000 helper.
// ----------------------------------------------------------------------------
package vrte_pkg;

  // Field and register widths.
  localparam int STEP_W  = 21;  // voltage step in microvolts
  localparam int SLEW_W  = 16;  // slew rate in microvolts per microsecond
  localparam int CLOCK_W = 27;  // clock rate in hertz
  localparam int KHZ_W   = 18;  // clock rate in kilohertz
  localparam int PRESC_W = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 1;

  // Product of kilohertz and ramp time in microseconds.
  localparam int PROD_W = KHZ_W + STEP_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE = 1'd1;

  // Reset values. The clock rate is held in kilohertz: 38400000 Hz.
  localparam logic [SLEW_W-1:0] SLEW_RESET    = 16'd9000;
  localparam logic [KHZ_W-1:0]  CLOCK_KHZ_RESET = 18'd38400;

  // Prescaler select codes.
  localparam logic [PRESC_W-1:0] PRESC_DIV64   = 2'd0;
  localparam logic [PRESC_W-1:0] PRESC_DIV256  = 2'd1;
  localparam logic [PRESC_W-1:0] PRESC_DIV512  = 2'd2;
  localparam logic [PRESC_W-1:0] PRESC_DIV2048 = 2'd3;

  // Bounds on the product for each prescaler. The count after division by
  // 1000 and by 64 times the prescaler ratio stays at or below 63 exactly
  // when the product is below 64 * 64000 times that ratio.
  localparam logic [PROD_W-1:0] PROD_LIM_DIV64   = 39'd4096000;
  localparam logic [PROD_W-1:0] PROD_LIM_DIV256  = 39'd16384000;
  localparam logic [PROD_W-1:0] PROD_LIM_DIV512  = 39'd32768000;
  localparam logic [PROD_W-1:0] PROD_LIM_DIV2048 = 39'd131072000;

  // Right shifts that apply the factor 64 times the prescaler ratio.
  localparam int SHIFT_DIV64   = 6;
  localparam int SHIFT_DIV256  = 8;
  localparam int SHIFT_DIV512  = 9;
  localparam int SHIFT_DIV2048 = 11;

  // Reciprocal of 1000 scaled by 2^37, rounded up. Exact for x below 2^27.
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 37;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 28'd137438954;

  // Default depth of the result buffer; enough for every item in flight.
  localparam int OUT_FIFO_DEPTH_DEF = 32;

  typedef struct packed {
    logic [PRESC_W-1:0] prescaler;
    logic [COUNT_W-1:0] ramp_count;
    logic               invalid;
  } result_t;

  // floor(x / 1000) for a 27-bit value, by multiplication with the reciprocal.
  function automatic logic [KHZ_W-1:0] div1000(input logic [CLOCK_W-1:0] x);
    logic [CLOCK_W+RECIP_W-1:0] prod;
    prod = (CLOCK_W+RECIP_W)'(x) * (CLOCK_W+RECIP_W)'(RECIP_1000);
    return prod[RECIP_SHIFT +: KHZ_W];
  endfunction

endpackage

// ----- hw/rtl/voltage_ramp_time_encoder.sv -----
// ----------------------------------------------------------------------------
// voltage_ramp_time_encoder: ramp setting from a voltage step
// Turns a voltage step into a prescaler select and a scaled cycle count.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_voltage_step
//   out_     output     out_valid / out_ready   out_prescaler, out_ramp_count,
//                                               out_invalid
//   cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is taken per cycle while in_ready is high. Each item passes the
// 21 stages of the step / slew divider, one kilohertz multiply, one
// reciprocal multiply with the prescaler compare, then the result buffer.
// The pipeline never stalls; the result buffer holds every item in flight,
// so in_ready drops only when OUT_FIFO_DEPTH items are accepted but not yet
// transferred out. A synchronous low rst_n empties the pipeline and buffer
// and restores the register reset values. cfg_ready is always high.
//
module voltage_ramp_time_encoder #(
  // Result buffer depth; must be at least the pipeline latency.
  parameter int OUT_FIFO_DEPTH = vrte_pkg::OUT_FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vrte_pkg::STEP_W-1:0]    in_voltage_step,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vrte_pkg::PRESC_W-1:0]   out_prescaler,
  output logic [vrte_pkg::COUNT_W-1:0]   out_ramp_count,
  output logic                          out_invalid,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vrte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrte_pkg::CLOCK_W-1:0]   cfg_data
);

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(OUT_FIFO_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers. The clock rate is converted to kilohertz when it
  // is written, so the datapath only ever sees the kilohertz value.
  // --------------------------------------------------------------------------
  logic [vrte_pkg::SLEW_W-1:0] slew_rate_r;
  logic [vrte_pkg::KHZ_W-1:0]  clock_khz_r;
  logic                        slew_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_rate_r <= vrte_pkg::SLEW_RESET;
      clock_khz_r <= vrte_pkg::CLOCK_KHZ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vrte_pkg::REG_SLEW_RATE: begin
          slew_rate_r <= cfg_data[vrte_pkg::SLEW_W-1:0];
        end
        vrte_pkg::REG_CLOCK_RATE: begin
          clock_khz_r <= vrte_pkg::div1000(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // A zero slew rate makes the ramp time meaningless; such items are invalid.
  // Users must change registers only while the block is idle (unchecked).
  assign slew_zero = (slew_rate_r == '0);

  // --------------------------------------------------------------------------
  // Ramp time in microseconds: voltage step divided by slew rate.
  // --------------------------------------------------------------------------
  logic                        in_xfer;
  logic                        div_valid;
  logic [vrte_pkg::STEP_W-1:0] div_quot;

  assign in_xfer = in_valid && in_ready;

  vrte_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .dividend (in_voltage_step),
    .divisor  (slew_rate_r),
    .out_valid(div_valid),
    .quotient (div_quot)
  );

  // --------------------------------------------------------------------------
  // Stage A: clock cycles times 1000, as kilohertz times microseconds.
  // --------------------------------------------------------------------------
  logic                        a_vld_r;
  logic [vrte_pkg::PROD_W-1:0] a_prod_r;
  logic [vrte_pkg::PROD_W-1:0] a_prod_nxt;

  assign a_prod_nxt = vrte_pkg::PROD_W'(clock_khz_r) * vrte_pkg::PROD_W'(div_quot);

  always_ff @(posedge clk) begin
    a_prod_r <= a_prod_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage B: the prescaler follows from compares of the product against
  // fixed bounds. Below the largest bound the product fits in 27 bits, and
  // the cycle count is that value divided by 1000.
  // --------------------------------------------------------------------------
  logic                         b_vld_r;
  logic                         b_ovf_r;
  logic [vrte_pkg::PRESC_W-1:0] b_presc_r;
  logic [vrte_pkg::KHZ_W-1:0]   b_cycles_r;
  logic                         b_ovf_nxt;
  logic [vrte_pkg::PRESC_W-1:0] b_presc_nxt;
  logic [vrte_pkg::KHZ_W-1:0]   b_cycles_nxt;

  always_comb begin
    b_ovf_nxt    = (a_prod_r >= vrte_pkg::PROD_LIM_DIV2048);
    b_cycles_nxt = vrte_pkg::div1000(a_prod_r[vrte_pkg::CLOCK_W-1:0]);
    if (a_prod_r < vrte_pkg::PROD_LIM_DIV64) begin
      b_presc_nxt = vrte_pkg::PRESC_DIV64;
    end else if (a_prod_r < vrte_pkg::PROD_LIM_DIV256) begin
      b_presc_nxt = vrte_pkg::PRESC_DIV256;
    end else if (a_prod_r < vrte_pkg::PROD_LIM_DIV512) begin
      b_presc_nxt = vrte_pkg::PRESC_DIV512;
    end else begin
      b_presc_nxt = vrte_pkg::PRESC_DIV2048;
    end
  end

  always_ff @(posedge clk) begin
    b_ovf_r    <= b_ovf_nxt;
    b_presc_r  <= b_presc_nxt;
    b_cycles_r <= b_cycles_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= div_valid;
      b_vld_r <= a_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: scale the cycle count by the prescaler and add one, or flag the
  // item invalid on overflow or zero slew rate, then buffer the result.
  // --------------------------------------------------------------------------
  logic [vrte_pkg::KHZ_W-1:0] c_scaled;
  vrte_pkg::result_t          c_res;

  always_comb begin
    case (b_presc_r)
      vrte_pkg::PRESC_DIV64:   c_scaled = b_cycles_r >> vrte_pkg::SHIFT_DIV64;
      vrte_pkg::PRESC_DIV256:  c_scaled = b_cycles_r >> vrte_pkg::SHIFT_DIV256;
      vrte_pkg::PRESC_DIV512:  c_scaled = b_cycles_r >> vrte_pkg::SHIFT_DIV512;
      vrte_pkg::PRESC_DIV2048: c_scaled = b_cycles_r >> vrte_pkg::SHIFT_DIV2048;
      default:                 c_scaled = b_cycles_r >> vrte_pkg::SHIFT_DIV2048;
    endcase
    if (b_ovf_r || slew_zero) begin
      c_res.prescaler  = vrte_pkg::PRESC_DIV64;
      c_res.ramp_count = '0;
      c_res.invalid    = 1'b1;
    end else begin
      // Without overflow the scaled count is at most 63.
      c_res.prescaler  = b_presc_r;
      c_res.ramp_count = {1'b0, c_scaled[vrte_pkg::COUNT_W-2:0]} + vrte_pkg::COUNT_W'(1);
      c_res.invalid    = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer. occ_r counts items accepted and not yet transferred out;
  // since it never exceeds the depth, the buffer always has room for every
  // item still in the pipeline, and the pipeline never has to stall.
  // --------------------------------------------------------------------------
  vrte_pkg::result_t fifo_mem_r [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  fifo_cnt_r;
  logic [CNT_W-1:0]  occ_r;
  logic              fifo_wr;
  logic              fifo_rd;
  vrte_pkg::result_t out_res;

  assign fifo_wr = b_vld_r;
  assign fifo_rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (fifo_wr) begin
      fifo_mem_r[wr_ptr_r] <= c_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (fifo_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (fifo_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (fifo_wr && !fifo_rd) begin
        fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
      end else if (!fifo_wr && fifo_rd) begin
        fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
      end
      if (in_xfer && !fifo_rd) begin
        occ_r <= occ_r + CNT_W'(1);
      end else if (!in_xfer && fifo_rd) begin
        occ_r <= occ_r - CNT_W'(1);
      end
    end
  end

  assign in_ready       = (occ_r != CNT_FULL);
  assign out_valid      = (fifo_cnt_r != '0);
  assign out_res        = fifo_mem_r[rd_ptr_r];
  assign out_prescaler  = out_res.prescaler;
  assign out_ramp_count = out_res.ramp_count;
  assign out_invalid    = out_res.invalid;

`ifndef SYNTHESIS
  // The number of items in flight stays within the buffer depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_FULL)
    else $error("items in flight exceed the result buffer depth");

  // Buffered results are a subset of the items accepted.
  a_fifo_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= occ_r)
    else $error("result buffer holds more items than were accepted");

  // A result leaving the pipeline never meets a full buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr |-> (fifo_cnt_r != CNT_FULL) || fifo_rd)
    else $error("result written into a full buffer");

  // An invalid result carries zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> (out_prescaler == '0) && (out_ramp_count == '0))
    else $error("invalid result with nonzero fields");

  // A valid result has a count from 1 to 64.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invalid |->
      (out_ramp_count != '0) && (out_ramp_count <= vrte_pkg::COUNT_W'(64)))
    else $error("ramp count out of range");
`endif

endmodule

// ----- hw/rtl/vrte_div.sv -----
// ----------------------------------------------------------------------------
// vrte_div: pipelined restoring divider
// Divides the voltage step by the slew rate, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vrte_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [vrte_pkg::STEP_W-1:0] dividend,
  input  logic [vrte_pkg::SLEW_W-1:0] divisor,
  output logic                       out_valid,
  output logic [vrte_pkg::STEP_W-1:0] quotient
);

  localparam int NS    = vrte_pkg::STEP_W;
  localparam int REM_W = vrte_pkg::SLEW_W;

  // Each stage holds the partial remainder and a word that shifts the
  // remaining dividend bits out at the top and the quotient bits in below.
  logic [REM_W-1:0] rem_r   [NS];
  logic [NS-1:0]    dq_r    [NS];
  logic [NS-1:0]    vld_r;
  logic [REM_W-1:0] rem_nxt [NS];
  logic [NS-1:0]    dq_nxt  [NS];

  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [NS-1:0]    dq_in;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        rem_in = '0;
        dq_in  = dividend;
      end else begin
        rem_in = rem_r[i-1];
        dq_in  = dq_r[i-1];
      end
      trial = {rem_in, dq_in[NS-1]};
      diff  = trial - {1'b0, divisor};
      // A clear top bit of the difference means the trial is not below the divisor.
      if (!diff[REM_W]) begin
        rem_nxt[i] = diff[REM_W-1:0];
      end else begin
        rem_nxt[i] = trial[REM_W-1:0];
      end
      dq_nxt[i] = {dq_in[NS-2:0], !diff[REM_W]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      rem_r[i] <= rem_nxt[i];
      dq_r[i]  <= dq_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NS-1];
  assign quotient  = dq_r[NS-1];

endmodule
